/* rtl/gcr_sector_data_prenibblizer_assert.svh */
// assertion macros for the sector data prenibblizer
// expects clk and arst_n in the scope of the module that includes it
`ifndef GCR_SECTOR_DATA_PRENIBBLIZER_ASSERT_SVH
`define GCR_SECTOR_DATA_PRENIBBLIZER_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define GCR_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while in reset
`define GCR_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/gcr_pn_pkg.sv */
// shared constants and types for the sector data prenibblizer
// no dependencies
`default_nettype none

package gcr_pn_pkg;

	localparam int unsigned SECTOR_BYTES = 524;
	localparam int unsigned POS_W        = $clog2(SECTOR_BYTES);
	localparam logic [POS_W-1:0] LAST_POS = POS_W'(SECTOR_BYTES - 1);

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned SUM_W  = 9;
	localparam int unsigned SYM_W  = 6;

	// symbols per full group of three bytes, and for the sector tail
	localparam int unsigned GROUP_SYMS = 4;
	localparam int unsigned TAIL_SYMS  = 7;
	localparam int unsigned BUF_DEPTH  = TAIL_SYMS;
	localparam int unsigned CNT_W      = $clog2(BUF_DEPTH + 1);

	// position of a byte within its group of three
	typedef enum logic [2:0] {
		PH_FIRST  = 3'b001,
		PH_SECOND = 3'b010,
		PH_THIRD  = 3'b100
	} phase_t;

endpackage

`default_nettype wire

/* rtl/gcr_sector_data_prenibblizer.sv */
// Sector data prenibblizer: 6-and-2 data field encoding of a 524-byte sector.
// Uses gcr_pn_pkg and the assertion macros in gcr_sector_data_prenibblizer_assert.svh.
//
// Input channel s_*: one sector byte per item in s_tdata, 12 tag bytes then
// 512 data bytes. Output channel m_*: one 6-bit symbol per item in the low
// bits of m_tdata, m_tlast high on the final checksum symbol of the sector.
// A byte is registered in the input register when accepted and is processed
// from there; the third byte of a group loads the symbols into the output
// queue registers. Every third byte loads four symbols into a seven-entry
// output queue, the last sector byte loads seven; the queue sends one symbol
// per cycle while m_tready is high. The third byte of a group and the last
// sector byte move on only when the queue is empty or sends its final entry
// in that cycle. Other bytes never wait for the queue. When the receiver
// stalls, the queue holds its head symbol and the input register fills,
// after which s_tready drops. Reset clears the checksums, the byte count,
// the input register and the queue; after the last sector byte the
// checksums and the byte count return to zero on their own and the next
// byte starts a new sector.
`default_nettype none

module gcr_sector_data_prenibblizer (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,   // [7:0] data_byte
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic [7:0]      m_tdata,   // [5:0] symbol, [7:6] zero
	output logic            m_tlast    // last
);

	`include "gcr_sector_data_prenibblizer_assert.svh"

	localparam int unsigned BW = gcr_pn_pkg::BYTE_W;
	localparam int unsigned SW = gcr_pn_pkg::SUM_W;
	localparam int unsigned YW = gcr_pn_pkg::SYM_W;
	localparam int unsigned DEPTH = gcr_pn_pkg::BUF_DEPTH;
	localparam int unsigned CW = gcr_pn_pkg::CNT_W;
	localparam int unsigned PW = gcr_pn_pkg::POS_W;
	localparam logic [CW-1:0] GROUP_CNT = CW'(gcr_pn_pkg::GROUP_SYMS);
	localparam logic [CW-1:0] TAIL_CNT  = CW'(gcr_pn_pkg::TAIL_SYMS);

	// input register
	logic          valid_s1;
	logic [BW-1:0] data_s1;

	// encoder state
	logic [SW-1:0]      sum_a_q, sum_b_q, sum_c_q;
	logic [PW-1:0]      pos_q;
	logic [BW-1:0]      held_first_q, held_second_q;
	gcr_pn_pkg::phase_t phase_q;

	// output queue
	logic [YW-1:0] sym_q [DEPTH];
	logic [CW-1:0] cnt_q;
	logic          last_q;

	// next state and load values
	logic [SW-1:0]      sum_a_n, sum_b_n, sum_c_n;
	logic [PW-1:0]      pos_n;
	logic [BW-1:0]      held_first_n, held_second_n;
	gcr_pn_pkg::phase_t phase_n;
	logic [YW-1:0]      load_sym [DEPTH];
	logic [CW-1:0]      load_cnt;
	logic               load_last;
	logic               produces;
	logic               at_last;

	logic [BW-1:0] rot_a;
	logic [BW-1:0] third;
	logic          buf_free;
	logic          s1_adv;
	logic          buf_load;
	logic          pop;

	// used by the assertions only
	logic group_adv;
	logic tail_adv;
	logic state_clear;

	assign at_last = (pos_q == gcr_pn_pkg::LAST_POS);
	assign rot_a   = {sum_a_q[BW-2:0], sum_a_q[BW-1]};
	assign third   = data_s1 ^ sum_b_q[BW-1:0];

	always_comb begin
		sum_a_n       = sum_a_q;
		sum_b_n       = sum_b_q;
		sum_c_n       = sum_c_q;
		pos_n         = pos_q + PW'(1);
		held_first_n  = held_first_q;
		held_second_n = held_second_q;
		phase_n       = phase_q;
		produces      = 1'b0;
		load_cnt      = CW'(gcr_pn_pkg::GROUP_SYMS);
		load_last     = 1'b0;
		for (int i = 0; i < DEPTH; i++) begin
			load_sym[i] = '0;
		end
		unique case (phase_q)
			gcr_pn_pkg::PH_FIRST: begin
				// rotate within 8 bits, the bit that wraps also carries into sum_c
				sum_a_n      = {1'b0, rot_a};
				sum_c_n      = sum_c_q + {1'b0, data_s1} + {{(SW-1){1'b0}}, sum_a_q[BW-1]};
				held_first_n = data_s1 ^ rot_a;
				phase_n      = gcr_pn_pkg::PH_SECOND;
			end
			gcr_pn_pkg::PH_SECOND: begin
				sum_b_n       = sum_b_q + {1'b0, data_s1} + {{(SW-1){1'b0}}, sum_c_q[SW-1]};
				sum_c_n       = {1'b0, sum_c_q[BW-1:0]};
				held_second_n = data_s1 ^ sum_c_q[BW-1:0];
				phase_n       = gcr_pn_pkg::PH_THIRD;
				if (at_last) begin
					produces    = 1'b1;
					load_cnt    = CW'(gcr_pn_pkg::TAIL_SYMS);
					load_last   = 1'b1;
					load_sym[0] = {held_first_q[7:6], held_second_n[7:6], 2'b00};
					load_sym[1] = held_first_q[YW-1:0];
					load_sym[2] = held_second_n[YW-1:0];
					// checksum top bits: sum_c high, sum_a low
					load_sym[3] = {sum_c_n[7:6], sum_b_n[7:6], sum_a_q[7:6]};
					load_sym[4] = sum_c_n[YW-1:0];
					load_sym[5] = sum_b_n[YW-1:0];
					load_sym[6] = sum_a_q[YW-1:0];
					sum_a_n       = '0;
					sum_b_n       = '0;
					sum_c_n       = '0;
					pos_n         = '0;
					held_first_n  = '0;
					held_second_n = '0;
					phase_n       = gcr_pn_pkg::PH_FIRST;
				end
			end
			gcr_pn_pkg::PH_THIRD: begin
				// carry left in sum_a bit 8 is dropped by the next rotation
				sum_a_n     = sum_a_q + {1'b0, data_s1} + {{(SW-1){1'b0}}, sum_b_q[SW-1]};
				sum_b_n     = {1'b0, sum_b_q[BW-1:0]};
				phase_n     = gcr_pn_pkg::PH_FIRST;
				produces    = 1'b1;
				load_sym[0] = {held_first_q[7:6], held_second_q[7:6], third[7:6]};
				load_sym[1] = held_first_q[YW-1:0];
				load_sym[2] = held_second_q[YW-1:0];
				load_sym[3] = third[YW-1:0];
			end
			default: begin
				phase_n = gcr_pn_pkg::PH_FIRST;
			end
		endcase
	end

	assign pop      = m_tvalid && m_tready;
	assign buf_free = (cnt_q == '0) || ((cnt_q == CW'(1)) && m_tready);
	assign s1_adv   = valid_s1 && (!produces || buf_free);
	assign buf_load = s1_adv && produces;
	assign s_tready = !valid_s1 || s1_adv;

	assign m_tvalid = (cnt_q != '0);
	assign m_tdata  = {{(8-YW){1'b0}}, sym_q[0]};
	assign m_tlast  = last_q && (cnt_q == CW'(1));

	assign group_adv   = s1_adv && (phase_q == gcr_pn_pkg::PH_THIRD);
	assign tail_adv    = s1_adv && (phase_q == gcr_pn_pkg::PH_SECOND) && at_last;
	assign state_clear = (pos_q == '0) && (sum_a_q == '0) && (sum_b_q == '0) &&
		(sum_c_q == '0) && (phase_q == gcr_pn_pkg::PH_FIRST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			sum_a_q       <= '0;
			sum_b_q       <= '0;
			sum_c_q       <= '0;
			pos_q         <= '0;
			held_first_q  <= '0;
			held_second_q <= '0;
			phase_q       <= gcr_pn_pkg::PH_FIRST;
			cnt_q         <= '0;
			last_q        <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (s1_adv) begin
				sum_a_q       <= sum_a_n;
				sum_b_q       <= sum_b_n;
				sum_c_q       <= sum_c_n;
				pos_q         <= pos_n;
				held_first_q  <= held_first_n;
				held_second_q <= held_second_n;
				phase_q       <= phase_n;
			end
			if (buf_load) begin
				cnt_q  <= load_cnt;
				last_q <= load_last;
			end else if (pop) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			data_s1 <= s_tdata;
		end
		if (buf_load) begin
			for (int i = 0; i < DEPTH; i++) begin
				sym_q[i] <= load_sym[i];
			end
		end else if (pop) begin
			for (int i = 0; i < DEPTH - 1; i++) begin
				sym_q[i] <= sym_q[i+1];
			end
		end
	end

	`GCR_ASSERT_IMP(a_no_overrun, buf_load, !(m_tvalid && !m_tready), "queue loaded on a stall")
	`GCR_ASSERT_NXT(a_group_load, group_adv, cnt_q == GROUP_CNT && !last_q, "group load wrong")
	`GCR_ASSERT_NXT(a_tail_load, tail_adv, cnt_q == TAIL_CNT && last_q, "sector tail load wrong")
	`GCR_ASSERT_NXT(a_sector_reset, tail_adv, state_clear, "state not cleared after sector end")

endmodule

`default_nettype wire

/* tb/gcr_pn_symbol_checker.sv */
// symbol checker for the sector data prenibblizer: watches both streams, predicts
// the 6-and-2 symbols of each sector byte and compares them in order
// depends on gcr_pn_pkg for the sector size and the group phase codes
module gcr_pn_symbol_checker (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	input  wire logic       s_tready,
	input  wire logic [7:0] s_tdata,   // [7:0] data_byte
	input  wire logic       m_tvalid,
	input  wire logic       m_tready,
	input  wire logic [7:0] m_tdata,   // [5:0] symbol, [7:6] zero
	input  wire logic       m_tlast,   // last
	output int              fail_count,
	output int              symbols_owed,
	output int              bytes_taken,
	output int              symbols_taken,
	output int              sectors_closed
);

	typedef struct packed {
		logic [5:0] symbol;
		logic       last;
	} coded_sym_t;

	coded_sym_t owed_q[$];

	// running checksums: run_x is the rotating one
	logic [8:0] run_x, run_y, run_z;
	logic [9:0] byte_idx;
	logic [7:0] scr_first, scr_second;
	gcr_pn_pkg::phase_t grp_phase;

	function automatic void owe(input logic [5:0] sym, input logic last);
		coded_sym_t c;
		c.symbol = sym;
		c.last = last;
		owed_q.push_back(c);
	endfunction

	function automatic void restart_sector();
		run_x = '0;
		run_y = '0;
		run_z = '0;
		byte_idx = '0;
		scr_first = '0;
		scr_second = '0;
		grp_phase = gcr_pn_pkg::PH_FIRST;
	endfunction

	task automatic predict_symbols(input logic [7:0] v);
		logic [7:0] scr_third;
		case (grp_phase)
			gcr_pn_pkg::PH_FIRST: begin
				// rotate left within eight bits, bit 7 wraps into bit 0
				run_x = {run_x[7:0], 1'b0};
				if (run_x[8])
					run_x[0] = 1'b1;
				run_z = run_z + v;
				if (run_x[8]) begin
					run_z = run_z + 9'd1;
					run_x[8] = 1'b0;
				end
				scr_first = v ^ run_x[7:0];
				byte_idx = byte_idx + 10'd1;
				grp_phase = gcr_pn_pkg::PH_SECOND;
			end
			gcr_pn_pkg::PH_SECOND: begin
				run_y = run_y + v;
				if (run_z[8]) begin
					run_y = run_y + 9'd1;
					run_z[8] = 1'b0;
				end
				scr_second = v ^ run_z[7:0];
				if (byte_idx >= gcr_pn_pkg::SECTOR_BYTES - 1) begin
					// short final group, then the checksum symbols
					owe({scr_first[7:6], scr_second[7:6], 2'b00}, 1'b0);
					owe(scr_first[5:0], 1'b0);
					owe(scr_second[5:0], 1'b0);
					owe({run_z[7:6], run_y[7:6], run_x[7:6]}, 1'b0);
					owe(run_z[5:0], 1'b0);
					owe(run_y[5:0], 1'b0);
					owe(run_x[5:0], 1'b1);
					restart_sector();
				end else begin
					byte_idx = byte_idx + 10'd1;
					grp_phase = gcr_pn_pkg::PH_THIRD;
				end
			end
			default: begin
				run_x = run_x + v;
				if (run_y[8]) begin
					run_x = run_x + 9'd1;
					run_y[8] = 1'b0;
				end
				scr_third = v ^ run_y[7:0];
				owe({scr_first[7:6], scr_second[7:6], scr_third[7:6]}, 1'b0);
				owe(scr_first[5:0], 1'b0);
				owe(scr_second[5:0], 1'b0);
				owe(scr_third[5:0], 1'b0);
				byte_idx = byte_idx + 10'd1;
				grp_phase = gcr_pn_pkg::PH_FIRST;
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		coded_sym_t want;
		if (!arst_n) begin
			restart_sector();
			owed_q.delete();
			fail_count = 0;
			bytes_taken = 0;
			symbols_taken = 0;
			sectors_closed = 0;
		end else begin
			// a byte taken at this edge cannot have a symbol out at the same edge
			if (m_tvalid && m_tready) begin
				symbols_taken++;
				if (m_tlast)
					sectors_closed++;
				if (owed_q.size() == 0) begin
					$display("%0t: stray symbol: expected none, actual tdata %02h last %0b",
						$time, m_tdata, m_tlast);
					fail_count++;
				end else begin
					want = owed_q.pop_front();
					if (m_tdata !== {2'b00, want.symbol}) begin
						$display("%0t: symbol mismatch: expected %02h, actual %02h",
							$time, {2'b00, want.symbol}, m_tdata);
						fail_count++;
					end
					if (m_tlast !== want.last) begin
						$display("%0t: last mismatch: expected %0b, actual %0b",
							$time, want.last, m_tlast);
						fail_count++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				bytes_taken++;
				predict_symbols(s_tdata);
			end
		end
		symbols_owed = owed_q.size();
	end

endmodule

/* tb/tb.sv */
// top of the prenibblizer testbench: clock, reset, byte stimulus, receiver stalls
// and the verdict; depends on gcr_pn_pkg, the block and gcr_pn_symbol_checker
module tb;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_CYCLES    = 300;
	localparam int DRAIN_CYCLES   = 20;
	localparam int OPENING_BYTES  = 24;
	localparam int PHASE_BYTES    = 103;

	logic       clk;
	logic       arst_n;
	logic       s_tvalid;
	logic       s_tready;
	logic [7:0] s_tdata;
	logic       m_tvalid;
	logic       m_tready;
	logic [7:0] m_tdata;
	logic       m_tlast;

	int send_idle_pct = 31;
	int recv_idle_pct = 68;
	bit hold_ask = 1'b0;
	bit hold_taken = 1'b0;
	int quiet_cycles = 0;

	int fail_count, symbols_owed, bytes_taken, symbols_taken, sectors_closed;

	// extremes of the byte and runs of ff that push every checksum into its carry
	logic [7:0] opening_seq [0:OPENING_BYTES-1] = '{
		8'h00, 8'h00, 8'h00, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
		8'hff, 8'h80, 8'h40, 8'hc0, 8'h3f, 8'h01, 8'hfe, 8'h7f,
		8'h55, 8'haa, 8'hff, 8'hff, 8'hff, 8'hc0, 8'hc0, 8'hc0
	};

	gcr_sector_data_prenibblizer uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	gcr_pn_symbol_checker checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.m_tlast        (m_tlast),
		.fail_count     (fail_count),
		.symbols_owed   (symbols_owed),
		.bytes_taken    (bytes_taken),
		.symbols_taken  (symbols_taken),
		.sectors_closed (sectors_closed)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(7))
			0: return 8'h00;
			1: return 8'hff;
			2: return {2'b11, 6'($urandom)};
			3: return {2'b00, 6'($urandom)};
			default: return 8'($urandom);
		endcase
	endfunction

	// valid stays high from one item to the next unless an idle cycle is drawn
	task automatic offer_byte(input logic [7:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		do @(posedge clk); while (!s_tready);
	endtask

	// receiver, with one long hold-off on request
	initial begin
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_ask && !hold_taken) begin
				hold_taken = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no item moved for %0d cycles", $time, quiet_cycles);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed opening, then random, sender light and receiver heavy idle
		foreach (opening_seq[i])
			offer_byte(opening_seq[i]);
		repeat (PHASE_BYTES - OPENING_BYTES)
			offer_byte(pick_byte());

		send_idle_pct = 68;
		recv_idle_pct = 31;
		repeat (PHASE_BYTES)
			offer_byte(pick_byte());

		// back to back, starting with a long receiver hold so the input side backs up
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_ask = 1'b1;
		repeat (PHASE_BYTES + 1)
			offer_byte(pick_byte());

		s_tvalid <= 1'b0;
		while (symbols_owed != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (symbols_owed != 0)
			$display("%0t: symbols left over: expected 0, actual %0d", $time, symbols_owed);

		$display("covered %0d sector bytes in, %0d symbols out, %0d checksum tails closed",
			bytes_taken, symbols_taken, sectors_closed);
		$display("stall mixes: sender-light, receiver-light, back to back after a %0d-cycle hold",
			HOLD_CYCLES);
		if (fail_count == 0 && symbols_owed == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
